@@ src/blr_pkg.sv @@
// Shared types and constants for the Bresenham line rasterizer.
// Holds the beat payload structs, command codes and register indexes; no dependencies.
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 16;
  localparam int ADDR_BITS = 24;
  localparam int DIM_BITS = 13;
  localparam int COLOR_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  // span is |a-b| of two coordinates, error term carries sign and headroom
  localparam int SPAN_BITS = COORD_BITS + 1;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int MUL_BITS = COORD_BITS + DIM_BITS;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STROKE_COLOR = 2'd2;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET = 13'd640;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [COLOR_BITS-1:0] STROKE_COLOR_RESET = 32'hFF00_0000;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         write_enable;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last;
  } out_beat_t;

  // pixel chosen by the stepping stage, before clipping and addressing
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         active;
    logic                         last;
  } pixel_t;

endpackage

`default_nettype wire

@@ src/bresenham_line_rasterizer_unit.sv @@
// Bresenham line rasterizer, top level.
// Uses blr_pkg for beat structs, command codes and register indexes.
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one command beat per
//   cycle. A start beat (cmd = CMD_START) loads both endpoints and yields the
//   first pixel; a step beat (cmd = CMD_STEP) advances the error term and
//   yields the next pixel. A step with no line in progress yields a beat with
//   write_enable low and last high, and leaves the line state untouched.
//   Output channel (out_valid / out_stall / out_data) gives exactly one beat
//   per input beat, in order, carrying coordinates, clipped write enable,
//   linear address y*frame_width+x, stroke color and last.
//   An accepted beat is held in the stepping stage, then moves to out_data when
//   the pipeline advances. Throughput: one beat per cycle unless out_stall
//   holds the output; the line state loop (error term and current point)
//   closes in the stepping stage, the address multiply in the second stage.
//   Stall: when out_stall holds the output register full, the stepping stage
//   fills and then in_stall rises; nothing is dropped or repeated.
//   Reset (rst, synchronous): empties both stages, clears the line state and
//   loads frame 640x480 with opaque black stroke color. The user must write
//   configuration (cfg_write/cfg_index/cfg_data) only while idle; not enforced.
module bresenham_line_rasterizer_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  blr_pkg::in_beat_t               in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output blr_pkg::out_beat_t                    out_data,
  input  wire                                   cfg_write,
  input  wire  [blr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  [blr_pkg::COLOR_BITS-1:0]        cfg_data
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int SB = blr_pkg::SPAN_BITS;
  localparam int EB = blr_pkg::ERR_BITS;

  // Configuration registers
  logic [blr_pkg::DIM_BITS-1:0]   frame_width;
  logic [blr_pkg::DIM_BITS-1:0]   frame_height;
  logic [blr_pkg::COLOR_BITS-1:0] stroke_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= blr_pkg::FRAME_WIDTH_RESET;
      frame_height <= blr_pkg::FRAME_HEIGHT_RESET;
      stroke_color <= blr_pkg::STROKE_COLOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        blr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[blr_pkg::DIM_BITS-1:0];
        blr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[blr_pkg::DIM_BITS-1:0];
        blr_pkg::REG_STROKE_COLOR: stroke_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline moves when the output register is empty or taken
  logic advance;
  logic in_accept;
  logic s1_valid;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Line state
  logic signed [CB-1:0] current_x, current_y, target_x, target_y;
  logic                 step_x_negative, step_y_negative;
  logic [SB-1:0]        span_x, span_y;
  logic signed [EB-1:0] error_term;
  logic                 line_active;

  logic signed [CB-1:0] current_x_next, current_y_next, target_x_next, target_y_next;
  logic                 step_x_negative_next, step_y_negative_next;
  logic [SB-1:0]        span_x_next, span_y_next;
  logic signed [EB-1:0] error_term_next;
  logic                 line_active_next;
  blr_pkg::pixel_t      pix_next;

  // Start-path temporaries
  logic signed [SB-1:0] dx, dy;
  logic                 start_done;
  // Step-path temporaries
  logic signed [EB:0]   e2, neg_span_y, span_x_ext;
  logic                 move_x, move_y, step_done;
  logic signed [EB-1:0] err_after_x;
  logic signed [CB-1:0] stepped_x, stepped_y;

  always_comb begin
    current_x_next       = current_x;
    current_y_next       = current_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    span_x_next          = span_x;
    span_y_next          = span_y;
    error_term_next      = error_term;
    line_active_next     = line_active;

    dx = SB'(in_data.x_end) - SB'(in_data.x_start);
    dy = SB'(in_data.y_end) - SB'(in_data.y_start);
    start_done = (in_data.x_start == in_data.x_end) && (in_data.y_start == in_data.y_end);

    e2          = {error_term, 1'b0};
    neg_span_y  = -$signed((EB+1)'(span_y));
    span_x_ext  = $signed((EB+1)'(span_x));
    move_x      = e2 > neg_span_y;
    move_y      = e2 < span_x_ext;
    err_after_x = move_x ? error_term - $signed(EB'(span_y)) : error_term;
    stepped_x   = step_x_negative ? current_x - CB'(1) : current_x + CB'(1);
    stepped_y   = step_y_negative ? current_y - CB'(1) : current_y + CB'(1);
    step_done   = ((move_x ? stepped_x : current_x) == target_x) &&
                  ((move_y ? stepped_y : current_y) == target_y);

    pix_next.x      = current_x;
    pix_next.y      = current_y;
    pix_next.active = 1'b0;
    pix_next.last   = 1'b1;

    if (in_data.cmd == blr_pkg::CMD_START) begin
      // Load a new line, dropping any line in progress
      current_x_next       = in_data.x_start;
      current_y_next       = in_data.y_start;
      target_x_next        = in_data.x_end;
      target_y_next        = in_data.y_end;
      span_x_next          = dx[SB-1] ? SB'(-dx) : SB'(dx);
      span_y_next          = dy[SB-1] ? SB'(-dy) : SB'(dy);
      step_x_negative_next = !(in_data.x_start < in_data.x_end);
      step_y_negative_next = !(in_data.y_start < in_data.y_end);
      error_term_next      = $signed(EB'(span_x_next)) - $signed(EB'(span_y_next));
      line_active_next     = !start_done;
      pix_next.x      = in_data.x_start;
      pix_next.y      = in_data.y_start;
      pix_next.active = 1'b1;
      pix_next.last   = start_done;
    end else if (line_active) begin
      // Advance one pixel along the major/minor axes
      current_x_next   = move_x ? stepped_x : current_x;
      current_y_next   = move_y ? stepped_y : current_y;
      error_term_next  = move_y ? err_after_x + $signed(EB'(span_x)) : err_after_x;
      line_active_next = !step_done;
      pix_next.x      = current_x_next;
      pix_next.y      = current_y_next;
      pix_next.active = 1'b1;
      pix_next.last   = step_done;
    end
  end

  // Stage 1: line state and chosen pixel
  blr_pkg::pixel_t s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x       <= '0;
      current_y       <= '0;
      target_x        <= '0;
      target_y        <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      span_x          <= '0;
      span_y          <= '0;
      error_term      <= '0;
      line_active     <= 1'b0;
      s1_valid        <= 1'b0;
    end else begin
      if (in_accept) begin
        current_x       <= current_x_next;
        current_y       <= current_y_next;
        target_x        <= target_x_next;
        target_y        <= target_y_next;
        step_x_negative <= step_x_negative_next;
        step_y_negative <= step_y_negative_next;
        span_x          <= span_x_next;
        span_y          <= span_y_next;
        error_term      <= error_term_next;
        line_active     <= line_active_next;
        s1_valid        <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix <= pix_next;
    end
  end

  // Stage 2: clip against the canvas and form the linear address
  logic                                 in_canvas, we;
  logic [blr_pkg::MUL_BITS-1:0]         addr_full;
  blr_pkg::out_beat_t                   out_next;

  always_comb begin
    in_canvas = !s1_pix.x[CB-1] && !s1_pix.y[CB-1] &&
                (blr_pkg::CMP_BITS'($unsigned(s1_pix.x)) < blr_pkg::CMP_BITS'(frame_width)) &&
                (blr_pkg::CMP_BITS'($unsigned(s1_pix.y)) < blr_pkg::CMP_BITS'(frame_height));
    we = s1_pix.active && in_canvas;
    addr_full = blr_pkg::MUL_BITS'($unsigned(s1_pix.y)) * blr_pkg::MUL_BITS'(frame_width)
              + blr_pkg::MUL_BITS'($unsigned(s1_pix.x));
    out_next.pixel_x       = s1_pix.x;
    out_next.pixel_y       = s1_pix.y;
    out_next.write_enable  = we;
    out_next.pixel_address = we ? blr_pkg::ADDR_BITS'(addr_full) : '0;
    out_next.pixel_color   = stroke_color;
    out_next.last          = s1_pix.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= out_next;
    end
  end

  // Checks
  a_we_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_enable |-> !out_data.pixel_x[CB-1] && !out_data.pixel_y[CB-1])
    else $error("write enable on a negative coordinate");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |-> out_data.pixel_address == '0)
    else $error("address not zero on a disabled pixel");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_pix.active |-> s1_pix.last)
    else $error("inactive pixel not marked last");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.cmd == blr_pkg::CMD_STEP && !line_active |=>
      $stable(current_x) && $stable(current_y) && $stable(error_term))
    else $error("step with no line changed the line state");

  a_point_line: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.cmd == blr_pkg::CMD_START &&
    in_data.x_start == in_data.x_end && in_data.y_start == in_data.y_end |=>
      !line_active && s1_pix.last)
    else $error("single-point line left active");

endmodule

`default_nettype wire
